@@ hdl/zds_pkg.sv @@
// Shared types and constants of the zone dwell suppressor.
package zds_pkg;

    typedef enum logic [1:0] {
        OP_LOAD        = 2'd0,
        OP_FRAME_START = 2'd1,
        OP_OBSERVE     = 2'd2,
        OP_FRAME_END   = 2'd3
    } op_t;

    localparam logic [1:0] REG_DWELL = 2'd0;
    localparam logic [1:0] REG_GAP   = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    localparam logic [31:0] DWELL_RESET = 32'd1000;
    localparam logic [31:0] GAP_RESET   = 32'd1000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  space_index;
        logic [2:0]  vertex_index;
        logic        vertex_last;
        logic [31:0] object_id;
        logic        is_vehicle;
        logic        has_source;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [47:0] frame_time_ms;
    } in_item_t;

    typedef struct packed {
        logic suppress;
        logic in_zone;
        logic status;
    } out_item_t;

    // Request from the controller to the zone tester, and its answer.
    typedef struct packed {
        logic start;
    } zt_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } zt_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZONE,
        ST_ZWAIT,
        ST_SCAN,
        ST_SREAD,
        ST_SCHECK,
        ST_MUL,
        ST_MUL2,
        ST_DECIDE,
        ST_CLEAR,
        ST_EVICT,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        ZS_IDLE,
        ZS_READ,
        ZS_MUL,
        ZS_CMP,
        ZS_NEXT
    } zt_state_t;

endpackage

@@ hdl/zds_if.sv @@
// Valid/ready stream interface carrying one payload.
interface zds_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/zone_dwell_suppressor.sv @@
// Top level of the zone dwell suppressor: controller and track table.
//
// Channels: in_ch carries one command per transfer (vertex load, frame start,
// observation, frame end); out_ch returns exactly one result per command with
// suppress, in_zone and status. The user writes the registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block itself does
// not enforce it. A vertex load, and any command while no zone is loaded,
// goes straight to the result. Frame start and frame end sweep the track table
// one entry a cycle. An observation walks the edges of the loaded zones until
// one of them holds the point; for a valid vehicle in a zone it then scans the
// track table for the id, reading each valid entry from the track memory, and
// makes the dwell decision. The zone edge walk and the track memory read port
// set how long it takes. One command is in flight at a time.
// Reset clears the zone vertex counts and the entry valid bits, and restores the
// register defaults; the vertex and track memories need no clearing.
// When the receiver stalls the result is held in the output register and the
// next command waits.
module zone_dwell_suppressor
    import zds_pkg::*;
#(
    parameter int MAX_ZONES    = 4,
    parameter int MAX_VERTICES = 8,
    parameter int MAX_TRACKS   = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    zds_if.sink          in_ch,
    zds_if.source        out_ch,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int TC = $clog2(MAX_TRACKS + 1);

    // configuration
    logic [31:0] dwell_reg, gap_reg;
    logic [30:0] tol_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= DWELL_RESET;
            gap_reg   <= GAP_RESET;
            tol_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DWELL: dwell_reg <= cfg_data;
                REG_GAP:   gap_reg   <= cfg_data;
                REG_TOL:   tol_reg   <= cfg_data[30:0];
                default:   ;
            endcase
        end
    end

    ctl_state_t state_reg, state_next;
    in_item_t   item_reg;
    out_item_t  res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    logic [TC-1:0] k_reg, k_next;
    logic [TW-1:0] slot_reg, slot_next;
    logic       free_ok_reg, free_ok_next;
    logic [TW-1:0] free_reg, free_next;
    logic [MAX_TRACKS-1:0] valid_reg, valid_next;
    logic [MAX_TRACKS-1:0] seen_reg, seen_next;

    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_ch.data;
        end
    end

    // zone tester
    zt_req_t zreq;
    zt_rsp_t zrsp;
    logic    any_zone;
    zds_zone_test #(.MAX_ZONES(MAX_ZONES), .MAX_VERTICES(MAX_VERTICES)) u_zone
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_fire && in_ch.data.operation == OP_LOAD),
        .wr_zone   (in_ch.data.space_index),
        .wr_vertex (in_ch.data.vertex_index),
        .wr_last   (in_ch.data.vertex_last),
        .wr_x      (in_ch.data.pos_x),
        .wr_y      (in_ch.data.pos_y),
        .px        (item_reg.pos_x),
        .py        (item_reg.pos_y),
        .req       (zreq),
        .rsp       (zrsp),
        .any_zone  (any_zone)
    );

    // track memory: id, anchor x/y, still_since, last_seen, parked
    localparam int EW = 32 + 32 + 32 + 48 + 48 + 1;
    logic [EW-1:0] tmem [MAX_TRACKS];
    logic [EW-1:0] trd_reg;
    logic [TW-1:0] trd_addr;
    logic          trd_en;
    logic          twr_en;
    logic [TW-1:0] twr_addr;
    logic [EW-1:0] twr_data;

    always_ff @(posedge clk)
    begin
        if (twr_en)
        begin
            tmem[twr_addr] <= twr_data;
        end
        if (trd_en)
        begin
            trd_reg <= tmem[trd_addr];
        end
    end

    logic [31:0] e_id;
    logic signed [31:0] e_ax, e_ay;
    logic [47:0] e_still, e_last;
    logic        e_park;
    assign {e_id, e_ax, e_ay, e_still, e_last, e_park} = trd_reg;

    // movement and timing
    logic signed [32:0] dx_s, dy_s;
    logic [31:0] dx_m, dy_m;
    assign dx_s = 33'($signed(item_reg.pos_x)) - 33'(e_ax);
    assign dy_s = 33'($signed(item_reg.pos_y)) - 33'(e_ay);
    assign dx_m = dx_s[32] ? 32'(-dx_s) : dx_s[31:0];
    assign dy_m = dy_s[32] ? 32'(-dy_s) : dy_s[31:0];

    logic [63:0] dx2_reg, dy2_reg, tol2_reg;
    logic        rev_reg, gap_big_reg, dwell_ok_reg;
    logic [47:0] t;
    assign t = item_reg.frame_time_ms;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            dx2_reg      <= 64'(dx_m) * 64'(dx_m);
            dy2_reg      <= 64'(dy_m) * 64'(dy_m);
            tol2_reg     <= 64'(tol_reg) * 64'(tol_reg);
            rev_reg      <= t < e_last;
            gap_big_reg  <= (t >= e_last) && ((t - e_last) > 48'(gap_reg));
            dwell_ok_reg <= (48'(t - e_still)) >= 48'(dwell_reg);
        end
    end

    logic moved;
    logic [64:0] dsum;
    assign dsum  = 65'(dx2_reg) + 65'(dy2_reg);
    assign moved = (dx2_reg > tol2_reg) || (dy2_reg > tol2_reg) || (dsum > 65'(tol2_reg));

    logic obs_ok;
    assign obs_ok = item_reg.is_vehicle && ($signed(item_reg.object_id) > 0)
                 && (t != '0);

    logic [TW-1:0] k_idx;
    assign k_idx = k_reg[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            seen_reg      <= '0;
            k_reg         <= '0;
            free_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            seen_reg      <= seen_next;
            k_reg         <= k_next;
            free_ok_reg   <= free_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        slot_reg <= slot_next;
        free_reg <= free_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        valid_next     = valid_reg;
        seen_next      = seen_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        free_ok_next   = free_ok_reg;
        free_next      = free_reg;
        zreq.start     = 1'b0;
        trd_en         = 1'b0;
        trd_addr       = k_idx;
        twr_en         = 1'b0;
        twr_addr       = slot_reg;
        twr_data       = {item_reg.object_id, item_reg.pos_x, item_reg.pos_y, t, t, 1'b0};
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_next = '0;
                    k_next   = '0;
                    if (in_ch.data.operation == OP_LOAD || !any_zone)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (in_ch.data.operation == OP_FRAME_START)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (in_ch.data.operation == OP_FRAME_END)
                    begin
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        state_next = ST_ZONE;
                    end
                end
            end
            ST_CLEAR:
            begin
                seen_next[k_idx] = 1'b0;
                k_next = TC'(k_reg + 1'b1);
                if (32'(k_reg) == MAX_TRACKS - 1)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_EVICT:
            begin
                if (!seen_reg[k_idx])
                begin
                    valid_next[k_idx] = 1'b0;
                end
                k_next = TC'(k_reg + 1'b1);
                if (32'(k_reg) == MAX_TRACKS - 1)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_ZONE:
            begin
                zreq.start = 1'b1;
                state_next = ST_ZWAIT;
            end
            ST_ZWAIT:
            begin
                if (zrsp.done)
                begin
                    res_next.in_zone = zrsp.hit;
                    if (!zrsp.hit || !obs_ok)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        k_next       = '0;
                        free_ok_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // search for the id; remember the first free entry
                if (32'(k_reg) == MAX_TRACKS)
                begin
                    if (!item_reg.has_source)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (!free_ok_reg)
                    begin
                        res_next.status = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        twr_en   = 1'b1;
                        twr_addr = free_reg;
                        valid_next[free_reg] = 1'b1;
                        seen_next[free_reg]  = 1'b1;
                        state_next = ST_OUT;
                    end
                end
                else if (!valid_reg[k_idx])
                begin
                    if (!free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = k_idx;
                    end
                    k_next = TC'(k_reg + 1'b1);
                end
                else
                begin
                    trd_en     = 1'b1;
                    state_next = ST_SREAD;
                end
            end
            ST_SREAD:
            begin
                state_next = ST_SCHECK;
            end
            ST_SCHECK:
            begin
                if (e_id == item_reg.object_id)
                begin
                    slot_next = k_idx;
                    seen_next[k_idx] = 1'b1;
                    if (!item_reg.has_source)
                    begin
                        res_next.suppress = e_park;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    k_next = TC'(k_reg + 1'b1);
                    state_next = ST_SCAN;
                end
            end
            ST_MUL:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                twr_en = 1'b1;
                if (moved || rev_reg || gap_big_reg)
                begin
                    twr_data = {item_reg.object_id, item_reg.pos_x, item_reg.pos_y, t, t, 1'b0};
                end
                else
                begin
                    twr_data = {e_id, e_ax, e_ay, e_still, t, dwell_ok_reg};
                    res_next.suppress = dwell_ok_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

`ifndef SYNTHESIS
    a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ch.ready)
        else $error("input taken while a result waits");
    a_suppress_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.suppress && res_reg.status))
        else $error("suppress with table full");
    a_zone_req: assert property (@(posedge clk) disable iff (!rst_n)
        zreq.start |=> state_reg == ST_ZWAIT)
        else $error("zone walk lost");
`endif

endmodule

@@ hdl/zds_zone_test.sv @@
// Zone vertex memory and crossing-number point-in-polygon tester.
module zds_zone_test
    import zds_pkg::*;
#(
    parameter int MAX_ZONES    = 4,
    parameter int MAX_VERTICES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_zone,
    input  logic [2:0]  wr_vertex,
    input  logic        wr_last,
    input  logic [31:0] wr_x,
    input  logic [31:0] wr_y,
    input  logic [31:0] px,
    input  logic [31:0] py,
    input  zt_req_t     req,
    output zt_rsp_t     rsp,
    output logic        any_zone
);

    localparam int ZW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_ZONES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);

    logic [63:0] vmem [DEPTH];
    logic [CW-1:0] count_reg [MAX_ZONES];

    // vertex load: ignore slots beyond the configured size
    logic wr_ok;
    assign wr_ok = wr_en && ({30'd0, wr_zone} < 32'(MAX_ZONES))
                         && ({29'd0, wr_vertex} < 32'(MAX_VERTICES));

    logic [AW-1:0] wr_addr;
    assign wr_addr = AW'(32'(wr_zone) * 32'(MAX_VERTICES) + 32'(wr_vertex));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int z = 0; z < MAX_ZONES; z++)
            begin
                count_reg[z] <= '0;
            end
        end
        else if (wr_ok && wr_last)
        begin
            count_reg[wr_zone[ZW-1:0]] <= CW'({29'd0, wr_vertex} + 32'd1);
        end
    end

    always_comb
    begin
        any_zone = 1'b0;
        for (int z = 0; z < MAX_ZONES; z++)
        begin
            if (count_reg[z] != '0)
            begin
                any_zone = 1'b1;
            end
        end
    end

    // walk state
    zt_state_t state_reg, state_next;
    logic [ZW-1:0] zone_reg, zone_next;
    logic [CW-1:0] step_reg, step_next;
    logic          inside_reg, inside_next;
    logic          hit_reg, hit_next;
    logic          done_reg, done_next;
    logic          phase_reg, phase_next;
    logic signed [32:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [63:0]   rd_data_reg;
    logic signed [65:0] p1_reg, p2_reg, p3_reg, p4_reg;

    logic [CW-1:0] n_cur;
    assign n_cur = count_reg[zone_reg];

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            vmem[wr_addr] <= {wr_x, wr_y};
        end
        if (rd_en)
        begin
            rd_data_reg <= vmem[rd_addr];
        end
    end

    // index of vertex a for step i is (i==0 ? n-1 : i-1) at phase 0, b = i at phase 1
    logic [CW-1:0] vidx;
    always_comb
    begin
        if (!phase_reg)
        begin
            vidx = (step_reg == '0) ? CW'(n_cur - 1'b1) : CW'(step_reg - 1'b1);
        end
        else
        begin
            vidx = step_reg;
        end
    end
    assign rd_addr = AW'(32'(zone_reg) * 32'(MAX_VERTICES) + 32'(vidx[VW-1:0]));

    logic signed [32:0] pxe, pye;
    assign pxe = {px[31], px};
    assign pye = {py[31], py};

    // vertex b sits in the read register from the end of ZS_READ until the next read
    logic signed [32:0] bxw, byw;
    assign bxw = {rd_data_reg[63], rd_data_reg[63:32]};
    assign byw = {rd_data_reg[31], rd_data_reg[31:0]};

    // products: edge collinearity and crossing comparison
    logic signed [33:0] d_pya, d_bxa, d_pxa, d_bya;
    assign d_pya = 34'(pye) - 34'(ay_reg);
    assign d_bxa = 34'(bxw) - 34'(ax_reg);
    assign d_pxa = 34'(pxe) - 34'(ax_reg);
    assign d_bya = 34'(byw) - 34'(ay_reg);

    logic on_seg, crosses, flip;
    always_comb
    begin
        on_seg = (p1_reg == p2_reg)
              && (pxe >= ((ax_reg < bx_reg) ? ax_reg : bx_reg))
              && (pxe <= ((ax_reg > bx_reg) ? ax_reg : bx_reg))
              && (pye >= ((ay_reg < by_reg) ? ay_reg : by_reg))
              && (pye <= ((ay_reg > by_reg) ? ay_reg : by_reg));
        crosses = (ay_reg > pye) != (by_reg > pye);
        // p3 = (px-ax)*d, p4 = (bx-ax)*(py-ay)
        flip = crosses && ((d_bya > 0) ? (p3_reg < p4_reg) : (p3_reg > p4_reg));
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ZS_MUL)
        begin
            p1_reg <= 66'(d_pya * d_bxa);
            p2_reg <= 66'(d_pxa * d_bya);
            p3_reg <= 66'(d_pxa * d_bya);
            p4_reg <= 66'(d_bxa * d_pya);
        end
        if (state_reg == ZS_READ && phase_reg)
        begin
            ax_reg <= {rd_data_reg[63], rd_data_reg[63:32]};
            ay_reg <= {rd_data_reg[31], rd_data_reg[31:0]};
        end
        if (state_reg == ZS_MUL && !phase_reg)
        begin
            bx_reg <= {rd_data_reg[63], rd_data_reg[63:32]};
            by_reg <= {rd_data_reg[31], rd_data_reg[31:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ZS_IDLE;
            zone_reg   <= '0;
            step_reg   <= '0;
            inside_reg <= 1'b0;
            hit_reg    <= 1'b0;
            done_reg   <= 1'b0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            zone_reg   <= zone_next;
            step_reg   <= step_next;
            inside_reg <= inside_next;
            hit_reg    <= hit_next;
            done_reg   <= done_next;
            phase_reg  <= phase_next;
        end
    end

    // ZS_NEXT reads a at phase 0; in the next cycle ZS_READ reads b at phase 1 while a lands.
    always_comb
    begin
        state_next  = state_reg;
        zone_next   = zone_reg;
        step_next   = step_reg;
        inside_next = inside_reg;
        hit_next    = hit_reg;
        done_next   = 1'b0;
        phase_next  = phase_reg;
        rd_en       = 1'b0;
        case (state_reg)
            ZS_IDLE:
            begin
                if (req.start)
                begin
                    zone_next   = '0;
                    step_next   = '0;
                    inside_next = 1'b0;
                    hit_next    = 1'b0;
                    phase_next  = 1'b0;
                    state_next  = ZS_NEXT;
                end
            end
            ZS_NEXT:
            begin
                // start a zone, or finish
                if (hit_reg || n_cur == '0 || step_reg == n_cur)
                begin
                    if (!hit_reg && step_reg == n_cur && n_cur != '0 && inside_reg)
                    begin
                        hit_next = 1'b1;
                    end
                    if (hit_reg || (step_reg == n_cur && n_cur != '0 && inside_reg)
                        || 32'(zone_reg) == MAX_ZONES - 1)
                    begin
                        done_next  = 1'b1;
                        state_next = ZS_IDLE;
                    end
                    else
                    begin
                        zone_next   = ZW'(zone_reg + 1'b1);
                        step_next   = '0;
                        inside_next = 1'b0;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    phase_next = 1'b1;
                    state_next = ZS_READ;
                end
            end
            ZS_READ:
            begin
                rd_en      = 1'b1;
                phase_next = 1'b0;
                state_next = ZS_MUL;
            end
            ZS_MUL:
            begin
                state_next = ZS_CMP;
            end
            ZS_CMP:
            begin
                if (on_seg)
                begin
                    hit_next = 1'b1;
                end
                else if (flip)
                begin
                    inside_next = !inside_reg;
                end
                step_next  = CW'(step_reg + 1'b1);
                state_next = ZS_NEXT;
            end
            default:
            begin
                state_next = ZS_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;

endmodule

@@ tb/zds_checker.sv @@
// Scoreboard for the zone dwell suppressor: watches both channels and predicts each result.
`timescale 1ns / 1ps

module zds_checker
    import zds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    zds_if              in_ch,
    zds_if              out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int ZONES  = 4;
    localparam int VERTS  = 8;
    localparam int TRACKS = 32;

    typedef struct {
        bit                neg;
        longint unsigned   mag;
    } sprod_t;

    logic signed [31:0] zone_x [ZONES*VERTS];
    logic signed [31:0] zone_y [ZONES*VERTS];
    int unsigned        zone_cnt [ZONES];
    bit                 trk_valid [TRACKS];
    logic signed [31:0] trk_id [TRACKS];
    logic signed [31:0] anc_x [TRACKS];
    logic signed [31:0] anc_y [TRACKS];
    logic [47:0]        still_t [TRACKS];
    logic [47:0]        last_t [TRACKS];
    bit                 trk_parked [TRACKS];
    bit                 trk_seen [TRACKS];
    logic [31:0]        dwell_ms;
    logic [31:0]        gap_ms;
    logic [30:0]        tol;

    out_item_t          expected_q [$];

    function automatic longint unsigned magn(longint d);
        return (d < 0) ? longint'(-d) : d;
    endfunction

    // Product wraps at 64 bits.
    function automatic sprod_t mul_diff(longint a, longint b);
        sprod_t r;
        r.mag = magn(a) * magn(b);
        r.neg = (r.mag != 0) && ((a < 0) != (b < 0));
        return r;
    endfunction

    function automatic int cmp_prod(sprod_t p, sprod_t q);
        if (p.neg != q.neg)
            return p.neg ? -1 : 1;
        if (p.mag == q.mag)
            return 0;
        if (!p.neg)
            return (p.mag < q.mag) ? -1 : 1;
        return (p.mag > q.mag) ? -1 : 1;
    endfunction

    function automatic bit on_edge(longint px, longint py, longint ax, longint ay,
                                   longint bx, longint by);
        if (cmp_prod(mul_diff(py - ay, bx - ax), mul_diff(px - ax, by - ay)) != 0)
            return 1'b0;
        return px >= ((ax < bx) ? ax : bx) && px <= ((ax > bx) ? ax : bx) &&
               py >= ((ay < by) ? ay : by) && py <= ((ay > by) ? ay : by);
    endfunction

    function automatic bit zone_hit(int z, longint px, longint py);
        int     n;
        int     j;
        bit     odd_cross;
        longint ax, ay, bx, by, d;
        int     c;
        n = zone_cnt[z];
        odd_cross = 1'b0;
        if (n == 0)
            return 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            ax = zone_x[z*VERTS + j];
            ay = zone_y[z*VERTS + j];
            bx = zone_x[z*VERTS + i];
            by = zone_y[z*VERTS + i];
            if (on_edge(px, py, ax, ay, bx, by))
                return 1'b1;
            if ((ay > py) != (by > py))
            begin
                d = by - ay;
                c = cmp_prod(mul_diff(px - ax, d), mul_diff(bx - ax, py - ay));
                if ((d > 0) ? (c < 0) : (c > 0))
                    odd_cross = !odd_cross;
            end
            j = i;
        end
        return odd_cross;
    endfunction

    function automatic out_item_t dwell_result(in_item_t it);
        out_item_t       r;
        longint          px, py;
        logic [47:0]     t;
        logic [47:0]     gap;
        int              slot;
        bit              hit, any, moved, reversed;
        longint unsigned tol2, dx, dy, dx2, dy2;
        r = '0;
        any = 1'b0;
        for (int z = 0; z < ZONES; z++)
            if (zone_cnt[z] != 0)
                any = 1'b1;
        case (op_t'(it.operation))
            OP_LOAD:
            begin
                zone_x[it.space_index*VERTS + it.vertex_index] = it.pos_x;
                zone_y[it.space_index*VERTS + it.vertex_index] = it.pos_y;
                if (it.vertex_last)
                    zone_cnt[it.space_index] = it.vertex_index + 1;
            end
            OP_FRAME_START:
            begin
                if (any)
                    for (int k = 0; k < TRACKS; k++)
                        trk_seen[k] = 1'b0;
            end
            OP_FRAME_END:
            begin
                if (any)
                    for (int k = 0; k < TRACKS; k++)
                        if (trk_valid[k] && !trk_seen[k])
                            trk_valid[k] = 1'b0;
            end
            default:
            begin
                if (!any)
                    return r;
                px = $signed(it.pos_x);
                py = $signed(it.pos_y);
                t = it.frame_time_ms;
                hit = 1'b0;
                for (int z = 0; z < ZONES && !hit; z++)
                    hit = zone_hit(z, px, py);
                r.in_zone = hit;
                if (!it.is_vehicle || $signed(it.object_id) <= 0 || t == 0 || !hit)
                    return r;
                slot = -1;
                for (int k = 0; k < TRACKS; k++)
                    if (slot < 0 && trk_valid[k] && trk_id[k] == it.object_id)
                        slot = k;
                if (!it.has_source)
                begin
                    if (slot >= 0)
                    begin
                        trk_seen[slot] = 1'b1;
                        r.suppress = trk_parked[slot];
                    end
                    return r;
                end
                if (slot < 0)
                begin
                    for (int k = 0; k < TRACKS; k++)
                        if (slot < 0 && !trk_valid[k])
                            slot = k;
                    if (slot < 0)
                    begin
                        r.status = 1'b1;
                        return r;
                    end
                    trk_valid[slot] = 1'b1;
                    trk_id[slot] = it.object_id;
                    anc_x[slot] = it.pos_x;
                    anc_y[slot] = it.pos_y;
                    still_t[slot] = t;
                    last_t[slot] = t;
                    trk_parked[slot] = 1'b0;
                    trk_seen[slot] = 1'b1;
                    return r;
                end
                trk_seen[slot] = 1'b1;
                tol2 = longint'(tol) * longint'(tol);
                dx = magn(px - anc_x[slot]);
                dy = magn(py - anc_y[slot]);
                dx2 = dx * dx;
                dy2 = dy * dy;
                moved = (dx2 > tol2) || (dy2 > tol2) || (dx2 + dy2 > tol2);
                reversed = t < last_t[slot];
                gap = reversed ? 48'd0 : t - last_t[slot];
                if (moved || reversed || gap > {16'd0, gap_ms})
                begin
                    anc_x[slot] = it.pos_x;
                    anc_y[slot] = it.pos_y;
                    still_t[slot] = t;
                    last_t[slot] = t;
                    trk_parked[slot] = 1'b0;
                    return r;
                end
                last_t[slot] = t;
                trk_parked[slot] = (t - still_t[slot]) >= {16'd0, dwell_ms};
                r.suppress = trk_parked[slot];
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want, got;
        if (!rst_n)
        begin
            for (int z = 0; z < ZONES; z++)
                zone_cnt[z] = 0;
            for (int k = 0; k < TRACKS; k++)
                trk_valid[k] = 1'b0;
            dwell_ms = DWELL_RESET;
            gap_ms = GAP_RESET;
            tol = '0;
            expected_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DWELL: dwell_ms = cfg_data;
                    REG_GAP:   gap_ms = cfg_data;
                    REG_TOL:   tol = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.suppress !== want.suppress)
                    begin
                        $error("suppress: expected %0d, got %0d", want.suppress, got.suppress);
                        errors++;
                    end
                    if (got.in_zone !== want.in_zone)
                    begin
                        $error("in_zone: expected %0d, got %0d", want.in_zone, got.in_zone);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_q = {expected_q, dwell_result(in_ch.data)};
            pending = expected_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the zone dwell suppressor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import zds_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int N_IDS      = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_fire;
    logic        quiet;
    int          errors;
    int          pending;
    int          stall_left;
    int          idle_cycles;

    zds_if #(.T(in_item_t))  in_ch (clk);
    zds_if #(.T(out_item_t)) out_ch (clk);

    zone_dwell_suppressor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    zds_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // zone shapes and vehicle positions, kept to aim observations
    logic signed [31:0] zv_x [4][8];
    logic signed [31:0] zv_y [4][8];
    int                 zv_n [4];
    logic signed [31:0] zc_x [4];
    logic signed [31:0] zc_y [4];
    int                 zc_r [4];
    logic signed [31:0] car_x [N_IDS+1];
    logic signed [31:0] car_y [N_IDS+1];
    logic [47:0]        now_ms;
    int                 sent;
    logic [30:0]        tol_now;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    always @(posedge clk)
        in_fire <= in_ch.valid && in_ch.ready;

    // receiver: random stall bursts, none once quiet
    always @(negedge clk)
    begin
        if (quiet)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [31:0] meters(int m);
        return m <<< 16;
    endfunction

    // every field random; callers overwrite what matters
    function automatic in_item_t noise_item(op_t op);
        in_item_t it;
        it.operation     = op;
        it.space_index   = 2'($urandom);
        it.vertex_index  = 3'($urandom);
        it.vertex_last   = 1'($urandom);
        it.object_id     = $urandom;
        it.is_vehicle    = 1'($urandom);
        it.has_source    = 1'($urandom);
        it.pos_x         = $urandom;
        it.pos_y         = $urandom;
        it.frame_time_ms = 48'({$urandom, $urandom});
        return it;
    endfunction

    function automatic in_item_t obs_item(logic [31:0] id, bit veh, bit src,
                                          logic [31:0] x, logic [31:0] y, logic [47:0] t);
        in_item_t it;
        it = noise_item(OP_OBSERVE);
        it.object_id     = id;
        it.is_vehicle    = veh;
        it.has_source    = src;
        it.pos_x         = x;
        it.pos_y         = y;
        it.frame_time_ms = t;
        return it;
    endfunction

    task automatic put_cmd(input in_item_t it);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(negedge clk);
        while (!in_fire);
        sent++;
    endtask

    task automatic load_vertex(int z, int v, bit last_v, logic [31:0] x, logic [31:0] y);
        in_item_t it;
        it = noise_item(OP_LOAD);
        it.space_index  = 2'(z);
        it.vertex_index = 3'(v);
        it.vertex_last  = last_v;
        it.pos_x        = x;
        it.pos_y        = y;
        zv_x[z][v] = x;
        zv_y[z][v] = y;
        put_cmd(it);
    endtask

    // vertices go around the center one quadrant after another
    task automatic load_zone(int z, int n);
        int q, mx, my;
        zc_x[z] = meters($urandom_range(0, 400) - 200);
        zc_y[z] = meters($urandom_range(0, 400) - 200);
        zc_r[z] = $urandom_range(5, 60) << 16;
        for (int v = 0; v < n; v++)
        begin
            q  = v * 4 / n;
            mx = $urandom_range(zc_r[z] / 4, zc_r[z]);
            my = $urandom_range(zc_r[z] / 4, zc_r[z]);
            if (q == 1 || q == 2)
                mx = -mx;
            if (q >= 2)
                my = -my;
            load_vertex(z, v, v == n - 1, zc_x[z] + mx, zc_y[z] + my);
        end
        zv_n[z] = n;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_regs(logic [31:0] dwell, logic [31:0] gap, logic [30:0] tol_v);
        settle();
        write_reg(REG_DWELL, dwell);
        write_reg(REG_GAP, gap);
        write_reg(REG_TOL, {1'b0, tol_v});
        tol_now = tol_v;
    endtask

    task automatic directed();
        logic [47:0] t0;
        put_cmd(obs_item(5, 1, 1, 0, 0, 1000));
        put_cmd(noise_item(OP_FRAME_START));
        put_cmd(noise_item(OP_FRAME_END));
        load_vertex(0, 0, 0, meters(-10), meters(-10));
        load_vertex(0, 1, 0, meters(10), meters(-10));
        load_vertex(0, 2, 0, meters(10), meters(10));
        load_vertex(0, 3, 1, meters(-10), meters(10));
        // two-vertex zone: a bare segment
        load_vertex(1, 0, 0, meters(100), meters(100));
        load_vertex(1, 1, 1, meters(120), meters(100));
        put_cmd(noise_item(OP_FRAME_START));
        put_cmd(obs_item(1, 1, 1, 0, 0, 1000));
        put_cmd(obs_item(1, 1, 1, 0, 0, 1500));
        put_cmd(obs_item(1, 1, 1, 0, 0, 2200));
        put_cmd(obs_item(1, 1, 0, 0, 0, 2200));
        put_cmd(obs_item(99, 1, 0, 0, 0, 2200));
        put_cmd(obs_item(2, 1, 1, meters(10), 0, 2200));
        put_cmd(obs_item(3, 1, 1, meters(10), meters(10), 2200));
        put_cmd(obs_item(4, 1, 1, meters(110), meters(100), 2200));
        put_cmd(obs_item(5, 0, 1, 0, 0, 2200));
        put_cmd(obs_item(0, 1, 1, 0, 0, 2200));
        put_cmd(obs_item(32'h8000_0000, 1, 1, 0, 0, 2200));
        put_cmd(obs_item(6, 1, 1, 0, 0, 0));
        put_cmd(obs_item(6, 1, 1, 32'h7fff_ffff, 32'h8000_0000, 2200));
        put_cmd(obs_item(6, 1, 1, 32'h8000_0000, 32'h7fff_ffff, 2200));
        put_cmd(obs_item(1, 1, 1, meters(1), 0, 2300));
        put_cmd(obs_item(1, 1, 1, meters(1), 0, 2000));
        t0 = 7000;
        put_cmd(obs_item(1, 1, 1, meters(1), 0, t0));
        put_cmd(obs_item(7, 1, 1, 0, 0, 48'hffff_ffff_ffff));
        put_cmd(noise_item(OP_FRAME_END));
        zv_n[0] = 4;
        zv_n[1] = 2;
        zc_x[0] = 0;
        zc_y[0] = 0;
        zc_r[0] = meters(10);
        zc_x[1] = meters(110);
        zc_y[1] = meters(100);
        zc_r[1] = meters(10);
    endtask

    task automatic random_obs();
        int          z, id, sel, j, k;
        logic [31:0] x, y, oid;
        logic [47:0] t;
        do
            z = $urandom_range(0, 3);
        while (zv_n[z] == 0);
        id = $urandom_range(1, N_IDS);
        sel = $urandom_range(0, 99);
        if (sel < 60 && car_x[id] != 0)
        begin
            x = car_x[id];
            y = car_y[id];
            k = $urandom_range(0, 9);
            if (k == 0)
                x = x + $urandom_range(0, tol_now > 4 ? tol_now / 2 : 4);
            else if (k == 1)
                y = y - ($urandom_range(1, 1 << 20));
        end
        else if (sel < 70)
        begin
            j = $urandom_range(0, zv_n[z] - 1);
            x = zv_x[z][j];
            y = zv_y[z][j];
        end
        else if (sel < 80)
        begin
            j = $urandom_range(0, zv_n[z] - 1);
            k = (j + 1) % zv_n[z];
            x = ($signed(zv_x[z][j]) + $signed(zv_x[z][k])) >>> 1;
            y = ($signed(zv_y[z][j]) + $signed(zv_y[z][k])) >>> 1;
        end
        else if (sel < 95)
        begin
            x = zc_x[z] + $urandom_range(0, zc_r[z]) - zc_r[z] / 2;
            y = zc_y[z] + $urandom_range(0, zc_r[z]) - zc_r[z] / 2;
        end
        else
        begin
            x = $urandom;
            y = $urandom;
        end
        car_x[id] = x;
        car_y[id] = y;
        oid = id;
        k = $urandom_range(0, 99);
        if (k < 4)
            oid = 0;
        else if (k < 8)
            oid = $urandom | 32'h8000_0000;
        else if (k < 12)
            oid = $urandom & 32'h7fff_ffff;
        t = now_ms;
        k = $urandom_range(0, 99);
        if (k < 5)
            t = now_ms - $urandom_range(1, 300);
        else if (k < 8)
            t = 0;
        else if (k < 10)
            t = 48'({$urandom, $urandom});
        put_cmd(obs_item(oid, $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0, x, y, t));
    endtask

    task automatic run_phase(int budget);
        int stop_at, nobs;
        stop_at = sent + budget;
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 19) == 0)
                load_zone($urandom_range(0, 3), $urandom_range(0, 5) == 0 ?
                          $urandom_range(1, 2) : $urandom_range(3, 8));
            if ($urandom_range(0, 15) == 0)
                put_cmd(noise_item(op_t'($urandom_range(1, 3))));
            now_ms = now_ms + $urandom_range(0, 700);
            put_cmd(noise_item(OP_FRAME_START));
            nobs = $urandom_range(3, 45);
            repeat (nobs)
                random_obs();
            put_cmd(noise_item(OP_FRAME_END));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        quiet        = 1'b0;
        sent         = 0;
        now_ms       = 3000;
        tol_now      = '0;
        for (int z = 0; z < 4; z++)
            zv_n[z] = 0;
        for (int i = 0; i <= N_IDS; i++)
        begin
            car_x[i] = 0;
            car_y[i] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed();
        load_zone(2, 6);
        load_zone(3, 3);
        set_regs(DWELL_RESET, GAP_RESET, 31'd0);
        run_phase(220);
        set_regs(32'd0, 32'd0, 31'd0);
        run_phase(220);
        set_regs(32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
        run_phase(220);
        set_regs(32'd1, 32'd400, 31'd65536);
        run_phase(220);
        set_regs($urandom_range(0, 3000), $urandom_range(0, 1500),
                 31'($urandom_range(0, 1 << 18)));
        run_phase(220);
        set_regs(DWELL_RESET, GAP_RESET, 31'd0);
        quiet = 1'b1;
        run_phase(200);

        settle();
        repeat (250) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
